[hdl/quadratic_real_root_solver_core_assert.svh]
// Assertion macros for the quadratic root solver checkers.
// Expects aclk and aresetn in the scope of the module that uses them.
`ifndef QUADRATIC_REAL_ROOT_SOLVER_CORE_ASSERT_SVH
`define QUADRATIC_REAL_ROOT_SOLVER_CORE_ASSERT_SVH

// Clocked check, masked while reset is asserted
`define QRRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked check that also holds across reset
`define QRRS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hdl/qrrs_pkg.sv]
// Shared types and constants for the quadratic real root solver.
// No dependencies; every other file but the assertion header refers to it by scoped names.
`default_nettype none

package qrrs_pkg;

    localparam int WORD_BITS = 32;
    localparam int ROOT_BITS = WORD_BITS + 1;
    localparam int DISC_BITS = 2 * ROOT_BITS;
    localparam int QMAG_BITS = WORD_BITS + 1;
    localparam int PROD_BITS = 2 * WORD_BITS;

    localparam logic [WORD_BITS-1:0] ROOT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] ROOT_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef logic [WORD_BITS-1:0] mag_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] coef_quad;
        logic signed [WORD_BITS-1:0] coef_lin;
        logic signed [WORD_BITS-1:0] coef_const;
    } coef_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] root_first;
        logic signed [WORD_BITS-1:0] root_second;
        logic [1:0]                  solve_status;
    } roots_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NEG_DISC = 2'd1,
        STAT_DEGEN    = 2'd2,
        STAT_SAT      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_QUAD,
        KIND_LINEAR,
        KIND_DEGEN,
        KIND_NEG_DISC
    } kind_t;

    // Classified item: signs and magnitudes of the coefficients
    typedef struct packed {
        kind_t kind;
        logic  aneg;
        mag_t  amag;
        logic  bneg;
        mag_t  bmag;
        logic  cneg;
        mag_t  cmag;
    } job_t;

    // Queue entry between front and back
    typedef struct packed {
        job_t                 job;
        logic [DISC_BITS-1:0] disc;
    } qentry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

[hdl/qrrs_front.sv]
// Front end: accepts coefficient items, forms the discriminant and classifies.
// Depends on qrrs_pkg.
`default_nettype none

module qrrs_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire qrrs_pkg::coef_t   s_data,
    input  wire qrrs_pkg::fifo_stat_t fifo_stat,
    output logic                   push,
    output qrrs_pkg::qentry_t      push_data
);

    localparam int W  = qrrs_pkg::WORD_BITS;
    localparam int PB = qrrs_pkg::PROD_BITS;
    localparam int DB = qrrs_pkg::DISC_BITS;

    logic              s1_valid_reg;
    qrrs_pkg::job_t    s1_job_reg;
    qrrs_pkg::job_t    s1_job_next;
    logic [PB-1:0]     s1_b2_reg, s1_b2_next;
    logic [PB-1:0]     s1_ac_reg, s1_ac_next;
    logic              s2_valid_reg;
    qrrs_pkg::qentry_t s2_entry_reg, s2_entry_next;
    logic              adv;

    // Front advances unless its last stage is blocked by a full queue
    assign adv     = !(s2_valid_reg && fifo_stat.full);
    assign s_ready = adv;
    assign push    = s2_valid_reg && adv;
    assign push_data = s2_entry_reg;

    // Sign/magnitude split and the two products
    always_comb begin
        qrrs_pkg::mag_t a_raw, b_raw, c_raw;
        a_raw = qrrs_pkg::mag_t'(s_data.coef_quad);
        b_raw = qrrs_pkg::mag_t'(s_data.coef_lin);
        c_raw = qrrs_pkg::mag_t'(s_data.coef_const);
        s1_job_next      = '0;
        s1_job_next.kind = qrrs_pkg::KIND_QUAD;
        s1_job_next.aneg = a_raw[W-1];
        s1_job_next.bneg = b_raw[W-1];
        s1_job_next.cneg = c_raw[W-1];
        s1_job_next.amag = a_raw[W-1] ? (~a_raw + qrrs_pkg::mag_t'(1)) : a_raw;
        s1_job_next.bmag = b_raw[W-1] ? (~b_raw + qrrs_pkg::mag_t'(1)) : b_raw;
        s1_job_next.cmag = c_raw[W-1] ? (~c_raw + qrrs_pkg::mag_t'(1)) : c_raw;
        s1_b2_next = PB'(s1_job_next.bmag) * PB'(s1_job_next.bmag);
        s1_ac_next = PB'(s1_job_next.amag) * PB'(s1_job_next.cmag);
    end

    // Discriminant and classification
    always_comb begin
        logic [DB-1:0] b2x, ac4;
        b2x = DB'(s1_b2_reg);
        ac4 = {s1_ac_reg, 2'b00};
        s2_entry_next     = '0;
        s2_entry_next.job = s1_job_reg;
        if (s1_job_reg.aneg != s1_job_reg.cneg) begin
            s2_entry_next.disc = b2x + ac4;
        end else begin
            s2_entry_next.disc = b2x - ac4;
        end
        if (s1_job_reg.amag == '0) begin
            s2_entry_next.job.kind = (s1_job_reg.bmag == '0) ? qrrs_pkg::KIND_DEGEN
                                                             : qrrs_pkg::KIND_LINEAR;
        end else if ((s1_job_reg.aneg == s1_job_reg.cneg) && (b2x < ac4)) begin
            s2_entry_next.job.kind = qrrs_pkg::KIND_NEG_DISC;
        end else begin
            s2_entry_next.job.kind = qrrs_pkg::KIND_QUAD;
        end
    end

    // Stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_job_reg   <= s1_job_next;
            s1_b2_reg    <= s1_b2_next;
            s1_ac_reg    <= s1_ac_next;
            s2_entry_reg <= s2_entry_next;
        end
    end

endmodule

`default_nettype wire

[hdl/qrrs_fifo.sv]
// Short queue between the front end and the solver back end.
// Depends on qrrs_pkg.
`default_nettype none

module qrrs_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire qrrs_pkg::qentry_t push_data,
    input  wire logic              pop,
    output qrrs_pkg::fifo_stat_t   stat,
    output qrrs_pkg::qentry_t      head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qrrs_pkg::qentry_t store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_data  = store_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hdl/qrrs_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on qrrs_pkg; carries the item's job record alongside.
`default_nettype none

module qrrs_sqrt_pipe (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           adv,
    input  wire logic                           in_valid,
    input  wire qrrs_pkg::job_t                 in_job,
    input  wire logic [qrrs_pkg::DISC_BITS-1:0] in_rad,
    output logic                                out_valid,
    output qrrs_pkg::job_t                      out_job,
    output logic [qrrs_pkg::ROOT_BITS-1:0]      out_root
);

    localparam int RB    = qrrs_pkg::ROOT_BITS;
    localparam int DB    = qrrs_pkg::DISC_BITS;
    localparam int REMB  = RB + 2;
    localparam int STEPS = RB;

    logic           valid_reg [STEPS];
    qrrs_pkg::job_t job_reg   [STEPS];
    logic [DB-1:0]  rad_reg   [STEPS], rad_next  [STEPS];
    logic [REMB-1:0] rem_reg  [STEPS], rem_next  [STEPS];
    logic [RB-1:0]  root_reg  [STEPS], root_next [STEPS];

    assign out_valid = valid_reg[STEPS-1];
    assign out_job   = job_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];

    // One restoring step per stage: bring in two radicand bits, try root*4+1
    always_comb begin
        logic [DB-1:0]   src_rad;
        logic [REMB-1:0] src_rem;
        logic [RB-1:0]   src_root;
        logic [REMB-1:0] rem_sh;
        logic [REMB-1:0] trial;
        for (int k = 0; k < STEPS; k++) begin
            if (k == 0) begin
                src_rad  = in_rad;
                src_rem  = '0;
                src_root = '0;
            end else begin
                src_rad  = rad_reg[k-1];
                src_rem  = rem_reg[k-1];
                src_root = root_reg[k-1];
            end
            rem_sh = {src_rem[RB-1:0], src_rad[DB-1 -: 2]};
            trial  = {src_root, 2'b01};
            rad_next[k] = src_rad << 2;
            if (rem_sh >= trial) begin
                rem_next[k]  = rem_sh - trial;
                root_next[k] = {src_root[RB-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_sh;
                root_next[k] = {src_root[RB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STEPS; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 0; k < STEPS; k++) begin
                valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < STEPS; k++) begin
                job_reg[k]  <= (k == 0) ? in_job : job_reg[(k == 0) ? 0 : k-1];
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

endmodule

`default_nettype wire

[hdl/qrrs_div_pipe.sv]
// Two-lane pipelined fixed-point divider, one quotient bit per stage,
// with sign, saturation and zero-divisor handling. Depends on qrrs_pkg.
`default_nettype none

module qrrs_div_pipe #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           adv,
    input  wire logic                           in_valid,
    input  wire qrrs_pkg::kind_t                in_kind,
    input  wire logic [qrrs_pkg::QMAG_BITS-1:0] in_nmag [2],
    input  wire logic [qrrs_pkg::QMAG_BITS-1:0] in_dmag [2],
    input  wire logic                           in_neg  [2],
    output logic                                out_valid,
    output qrrs_pkg::kind_t                     out_kind,
    output logic [qrrs_pkg::WORD_BITS-1:0]      out_word [2],
    output logic                                out_sat  [2]
);

    localparam int W     = qrrs_pkg::WORD_BITS;
    localparam int QB    = qrrs_pkg::QMAG_BITS;
    localparam int NB    = QB + FRAC_BITS;
    localparam int STEPS = NB;

    logic            valid_reg [STEPS];
    qrrs_pkg::kind_t kind_reg  [STEPS];
    logic [NB-1:0]   num_reg   [2][STEPS], num_next [2][STEPS];
    logic [QB-1:0]   rem_reg   [2][STEPS], rem_next [2][STEPS];
    logic [NB-1:0]   quo_reg   [2][STEPS], quo_next [2][STEPS];
    logic [QB-1:0]   dmag_reg  [2][STEPS];
    logic            neg_reg   [2][STEPS];

    assign out_valid = valid_reg[STEPS-1];
    assign out_kind  = kind_reg[STEPS-1];

    // Restoring division step for each lane and stage
    always_comb begin
        logic [NB-1:0] src_num;
        logic [QB-1:0] src_rem;
        logic [NB-1:0] src_quo;
        logic [QB-1:0] src_dmag;
        logic [QB:0]   rem_sh;
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < STEPS; k++) begin
                if (k == 0) begin
                    src_num  = NB'(in_nmag[l]) << FRAC_BITS;
                    src_rem  = '0;
                    src_quo  = '0;
                    src_dmag = in_dmag[l];
                end else begin
                    src_num  = num_reg[l][k-1];
                    src_rem  = rem_reg[l][k-1];
                    src_quo  = quo_reg[l][k-1];
                    src_dmag = dmag_reg[l][k-1];
                end
                rem_sh = {src_rem, src_num[NB-1]};
                num_next[l][k] = src_num << 1;
                if (rem_sh >= {1'b0, src_dmag}) begin
                    rem_next[l][k] = QB'(rem_sh - {1'b0, src_dmag});
                    quo_next[l][k] = {src_quo[NB-2:0], 1'b1};
                end else begin
                    rem_next[l][k] = QB'(rem_sh);
                    quo_next[l][k] = {src_quo[NB-2:0], 1'b0};
                end
            end
        end
    end

    // Clamp, sign and zero-divisor result at the last stage
    always_comb begin
        logic [NB-1:0] quo;
        logic [NB-1:0] limit;
        logic [W-1:0]  mag;
        logic          sat;
        for (int l = 0; l < 2; l++) begin
            quo   = quo_reg[l][STEPS-1];
            limit = (NB'(1) << (W - 1)) - NB'(!neg_reg[l][STEPS-1]);
            sat   = (dmag_reg[l][STEPS-1] != '0) && (quo > limit);
            mag   = sat ? limit[W-1:0] : quo[W-1:0];
            if (dmag_reg[l][STEPS-1] == '0) begin
                out_word[l] = '0;
            end else begin
                out_word[l] = neg_reg[l][STEPS-1] ? (~mag + W'(1)) : mag;
            end
            out_sat[l] = sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STEPS; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 0; k < STEPS; k++) begin
                valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < STEPS; k++) begin
                kind_reg[k] <= (k == 0) ? in_kind : kind_reg[(k == 0) ? 0 : k-1];
                for (int l = 0; l < 2; l++) begin
                    num_reg[l][k]  <= num_next[l][k];
                    rem_reg[l][k]  <= rem_next[l][k];
                    quo_reg[l][k]  <= quo_next[l][k];
                    dmag_reg[l][k] <= (k == 0) ? in_dmag[l]
                                               : dmag_reg[l][(k == 0) ? 0 : k-1];
                    neg_reg[l][k]  <= (k == 0) ? in_neg[l]
                                               : neg_reg[l][(k == 0) ? 0 : k-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

[hdl/qrrs_back.sv]
// Back end: square root, q formation, the two divisions and the result register.
// Depends on qrrs_pkg, qrrs_sqrt_pipe and qrrs_div_pipe.
`default_nettype none

module qrrs_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire qrrs_pkg::fifo_stat_t fifo_stat,
    input  wire qrrs_pkg::qentry_t    head_data,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output qrrs_pkg::roots_t          m_data
);

    localparam int W  = qrrs_pkg::WORD_BITS;
    localparam int QB = qrrs_pkg::QMAG_BITS;
    localparam int RB = qrrs_pkg::ROOT_BITS;

    logic             adv;
    logic             sq_valid;
    qrrs_pkg::job_t   sq_job;
    logic [RB-1:0]    sq_root;

    logic             sel_valid_reg;
    qrrs_pkg::kind_t  sel_kind_reg;
    logic [QB-1:0]    nmag_reg [2], nmag_next [2];
    logic [QB-1:0]    dmag_reg [2], dmag_next [2];
    logic             neg_reg  [2], neg_next  [2];

    logic             dv_valid;
    qrrs_pkg::kind_t  dv_kind;
    logic [W-1:0]     dv_word [2];
    logic             dv_sat  [2];

    logic             m_valid_reg;
    qrrs_pkg::roots_t m_data_reg, m_data_next;

    // Whole back end holds while a result waits on the receiver
    assign adv     = !(m_valid_reg && !m_ready);
    assign pop     = adv && !fifo_stat.empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    qrrs_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (!fifo_stat.empty),
        .in_job    (head_data.job),
        .in_rad    (head_data.disc),
        .out_valid (sq_valid),
        .out_job   (sq_job),
        .out_root  (sq_root)
    );

    // Form q and pick dividend/divisor per equation kind
    always_comb begin
        logic [QB:0]   qsum;
        logic [QB-1:0] qmag;
        qsum = (QB + 1)'(sq_job.bmag) + (QB + 1)'(sq_root);
        qmag = qsum[QB:1];
        for (int l = 0; l < 2; l++) begin
            nmag_next[l] = '0;
            dmag_next[l] = '0;
            neg_next[l]  = 1'b0;
        end
        case (sq_job.kind)
            qrrs_pkg::KIND_QUAD: begin
                nmag_next[0] = QB'(sq_job.cmag);
                dmag_next[0] = qmag;
                neg_next[0]  = sq_job.cneg ^ !sq_job.bneg;
                nmag_next[1] = qmag;
                dmag_next[1] = QB'(sq_job.amag);
                neg_next[1]  = !sq_job.bneg ^ sq_job.aneg;
            end
            qrrs_pkg::KIND_LINEAR: begin
                nmag_next[0] = QB'(sq_job.cmag);
                dmag_next[0] = QB'(sq_job.bmag);
                neg_next[0]  = !sq_job.cneg ^ sq_job.bneg;
            end
            default: begin
                nmag_next[0] = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg <= 1'b0;
        end else if (adv) begin
            sel_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sel_kind_reg <= sq_job.kind;
            for (int l = 0; l < 2; l++) begin
                nmag_reg[l] <= nmag_next[l];
                dmag_reg[l] <= dmag_next[l];
                neg_reg[l]  <= neg_next[l];
            end
        end
    end

    qrrs_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sel_valid_reg),
        .in_kind   (sel_kind_reg),
        .in_nmag   (nmag_reg),
        .in_dmag   (dmag_reg),
        .in_neg    (neg_reg),
        .out_valid (dv_valid),
        .out_kind  (dv_kind),
        .out_word  (dv_word),
        .out_sat   (dv_sat)
    );

    // Assemble roots and status
    always_comb begin
        m_data_next = '0;
        case (dv_kind)
            qrrs_pkg::KIND_QUAD: begin
                m_data_next.root_first   = $signed(dv_word[0]);
                m_data_next.root_second  = $signed(dv_word[1]);
                m_data_next.solve_status = (dv_sat[0] || dv_sat[1]) ? qrrs_pkg::STAT_SAT
                                                                     : qrrs_pkg::STAT_OK;
            end
            qrrs_pkg::KIND_LINEAR: begin
                m_data_next.root_first   = $signed(dv_word[0]);
                m_data_next.root_second  = $signed(dv_word[0]);
                m_data_next.solve_status = dv_sat[0] ? qrrs_pkg::STAT_SAT
                                                     : qrrs_pkg::STAT_OK;
            end
            qrrs_pkg::KIND_NEG_DISC: begin
                m_data_next.solve_status = qrrs_pkg::STAT_NEG_DISC;
            end
            default: begin
                m_data_next.solve_status = qrrs_pkg::STAT_DEGEN;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && dv_valid) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

[hdl/quadratic_real_root_solver_core.sv]
// Quadratic real root solver: solves a*x^2 + b*x + c = 0 on signed fixed-point words.
// Input channel s_*: one item carries coefficients a, b, c (coef_t).
// Result channel m_*: one item per input carries both roots and a status (roots_t):
//   ok, negative discriminant, a and b both zero, or a root saturated.
// Stages: the bit-per-stage square root has WORD_BITS+1 stages and the
//   bit-per-stage dividers have WORD_BITS+1+FRAC_BITS stages.
// Throughput: one item per cycle, sustained while m_ready is high.
// A front end (products, discriminant, classification) feeds a queue of
// QUEUE_DEPTH items; the back end pipeline drains it.
// When the receiver stalls, the back end holds in place; the front end keeps
// accepting until the queue fills, then drops s_ready.
// Reset (aresetn low, synchronous) empties the queue and every pipeline stage;
// no results are pending afterward.
// Depends on qrrs_pkg, qrrs_front, qrrs_fifo, qrrs_back.
`default_nettype none

module quadratic_real_root_solver_core #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire qrrs_pkg::coef_t   s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output qrrs_pkg::roots_t       m_data
);

    qrrs_pkg::fifo_stat_t fifo_stat;
    logic                 push;
    logic                 pop;
    qrrs_pkg::qentry_t    push_data;
    qrrs_pkg::qentry_t    head_data;

    qrrs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_data (push_data)
    );

    qrrs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .stat      (fifo_stat),
        .head_data (head_data)
    );

    qrrs_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fifo_stat (fifo_stat),
        .head_data (head_data),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

[hdl/qrrs_port_check.sv]
// Port-level checks on the solver's result channel, bound to the top level.
// Depends on qrrs_pkg and the assertion macro header.
`default_nettype none

`include "quadratic_real_root_solver_core_assert.svh"

module qrrs_port_check (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire qrrs_pkg::roots_t m_data
);

    logic flagged;
    logic roots_zero;
    logic first_clamped;
    logic second_clamped;

    // Status and root observations used by the checks below
    assign flagged        = (m_data.solve_status == qrrs_pkg::STAT_DEGEN)
                         || (m_data.solve_status == qrrs_pkg::STAT_NEG_DISC);
    assign roots_zero     = (m_data.root_first == '0) && (m_data.root_second == '0);
    assign first_clamped  = (m_data.root_first == qrrs_pkg::ROOT_MAX)
                         || (m_data.root_first == qrrs_pkg::ROOT_MIN);
    assign second_clamped = (m_data.root_second == qrrs_pkg::ROOT_MAX)
                         || (m_data.root_second == qrrs_pkg::ROOT_MIN);

    // A stalled result holds
    `QRRS_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped or changed while stalled")

    // Reset leaves nothing pending
    `QRRS_ASSERT_RST(a_reset, !aresetn |=> !m_valid, "result valid right after reset")

    // Flagged equations carry zero roots
    `QRRS_ASSERT(a_zero_roots, m_valid && flagged |-> roots_zero, "flagged result with nonzero root")

    // Saturation shows as a clamped root
    `QRRS_ASSERT(a_sat_clamp, m_valid && m_data.solve_status == qrrs_pkg::STAT_SAT |-> first_clamped || second_clamped, "saturation without clamped root")

endmodule

bind quadratic_real_root_solver_core qrrs_port_check u_port_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
